### rtl/svve_pkg.sv
`default_nettype none

package svve_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_DEPTH  = 16;
    localparam int COUNT_BITS       = 24;

    localparam int PHASE_W = 32;
    localparam int VOL_W   = 15;
    localparam int LEN_W   = 24;
    localparam int SMP_W   = 16;
    localparam int MAG_W   = 15;
    localparam int GAIN_W  = 17;
    localparam int CMP_W   = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam int SINE_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int SINE_SHIFT   = 18 - SINE_BITS;
    localparam int SINE_ADDR_W  = SINE_BITS - 1;

    localparam int EXP_NONZERO = 12;
    localparam int EXP_LIMIT   = (EXP_TABLE_DEPTH < EXP_NONZERO) ? EXP_TABLE_DEPTH : EXP_NONZERO;
    localparam int EXP_IDX_W   = $clog2(EXP_LIMIT);

    localparam int MUL_A_W   = 2 * VOL_W;
    localparam int MUL_B_W   = LEN_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int DIV_STEPS = LEN_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VIB_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_MODE  = 2'd3;

    typedef struct packed {
        logic                     opcode;
        logic [PHASE_W-1:0]       note_phase_inc;
        logic [VOL_W-1:0]         note_volume;
        logic [LEN_W-1:0]         note_length;
        logic [LEN_W-1:0]         attack_length;
        logic [LEN_W-1:0]         release_length;
        logic signed [SMP_W-1:0]  mix_in;
    } t_in_req;

    typedef struct packed {
        logic signed [SMP_W-1:0]  sample_out;
        logic                     note_done;
        logic                     clipped;
    } t_out_res;

    typedef logic [MAG_W-1:0]  t_sine_rom [SINE_QUARTER+1];
    typedef logic [GAIN_W-1:0] t_exp_rom  [EXP_LIMIT];

    function automatic logic [MAG_W-1:0] sine_mag_of(longint x);
        longint x2;
        longint u;
        longint v;
        longint s;
        longint m;
        x2 = (x * x) >>> 16;
        u  = 42112 - ((x2 * 4733) >>> 16);
        v  = 102919 - ((x2 * u) >>> 16);
        s  = (x * v) >>> 16;
        if (s > 65536) begin
            s = 65536;
        end
        m = (s * 32767 + 32768) >>> 16;
        if (m > 32767) begin
            m = 32767;
        end
        return m[MAG_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_QUARTER; i++) begin
            rom[i] = sine_mag_of(longint'(i) << SINE_SHIFT);
        end
        return rom;
    endfunction

    function automatic logic [GAIN_W-1:0] exp_gain_of(int d);
        logic [GAIN_W-1:0] g;
        unique case (d)
            0:       g = GAIN_W'(65536);
            1:       g = GAIN_W'(24110);
            2:       g = GAIN_W'(8869);
            3:       g = GAIN_W'(3263);
            4:       g = GAIN_W'(1200);
            5:       g = GAIN_W'(442);
            6:       g = GAIN_W'(162);
            7:       g = GAIN_W'(60);
            8:       g = GAIN_W'(22);
            9:       g = GAIN_W'(8);
            10:      g = GAIN_W'(3);
            11:      g = GAIN_W'(1);
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        for (int i = 0; i < EXP_LIMIT; i++) begin
            rom[i] = exp_gain_of(i);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam t_exp_rom  EXP_ROM  = build_exp_rom();

endpackage

`default_nettype wire

### rtl/svve_mul.sv
`default_nettype none

module svve_mul
    import svve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_busy,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [MUL_A_W:0]     n_sum;

    // One multiplier bit per cycle, least significant first; product bits
    // shift down into the low half as the multiplier bits are consumed.
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + MUL_CNT_W'(1);
            if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[MUL_A_W:1];
            r_lo <= {n_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

### rtl/svve_div.sv
`default_nettype none

module svve_div
    import svve_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [LEN_W-1:0] o_quot
);

    logic [LEN_W-1:0]     r_den;
    logic [LEN_W-1:0]     r_rem;
    logic [LEN_W:0]       r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [LEN_W:0]       n_shift;
    logic [LEN_W:0]       n_diff;
    logic                 n_ge;

    // Restoring division of one unit at the top bit position by the length,
    // one quotient bit per cycle.
    assign n_shift = {r_rem, (r_cnt == '0)};
    assign n_diff  = n_shift - {1'b0, r_den};
    assign n_ge    = n_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[LEN_W-1:0] : n_shift[LEN_W-1:0];
            r_quot <= {r_quot[LEN_W-1:0], n_ge};
        end
    end

    assign o_busy = r_busy;

    always_comb begin
        if (r_den == '0) begin
            o_quot = '0;
        end else if (r_quot[LEN_W]) begin
            o_quot = '1;
        end else begin
            o_quot = r_quot[LEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/sine_voice_vibrato_envelope.sv
// Channel   Direction  Handshake                  Payload
// in        request    i_in_valid / o_in_stall    i_in_data  (t_in_req)
// out       result     o_out_valid / i_out_stall  o_out_data (t_out_res)
// cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A tick request on a sounding note makes two passes through a pair of bit-serial
// multipliers, plus sine table reads and the sum. A tick on a silent voice skips
// these and goes straight to the sum; a load runs two 25-step serial divisions for
// the ramp reciprocals.
// Reset is synchronous and active low and clears the state, the output valid, the configuration and note registers.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits only at the point where its own result is written.
`default_nettype none

module sine_voice_vibrato_envelope
    import svve_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV_A = 4'd1;
    localparam logic [3:0] ST_DIV_R = 4'd2;
    localparam logic [3:0] ST_ROM_M = 4'd3;
    localparam logic [3:0] ST_ROM_V = 4'd4;
    localparam logic [3:0] ST_MUL_S = 4'd5;
    localparam logic [3:0] ST_MUL_A = 4'd6;
    localparam logic [3:0] ST_MUL_B = 4'd7;
    localparam logic [3:0] ST_SUM   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]              r_state;
    logic [3:0]              n_state;

    logic [PHASE_W-1:0]      r_vib_rate;
    logic [LEN_W-1:0]        r_vib_depth;
    logic                    r_att_mode;
    logic                    r_rel_mode;

    logic [PHASE_W-1:0]      r_base_inc;
    logic [VOL_W-1:0]        r_volume;
    logic [LEN_W-1:0]        r_duration;
    logic [LEN_W-1:0]        r_attack;
    logic [LEN_W-1:0]        r_release;
    logic [LEN_W-1:0]        r_att_rcp;
    logic [LEN_W-1:0]        r_rel_rcp;
    logic [PHASE_W-1:0]      r_main_phase;
    logic [PHASE_W-1:0]      r_vib_phase;
    logic [COUNT_BITS-1:0]   r_sample_index;

    logic signed [SMP_W-1:0] r_mix;
    logic                    r_active;
    logic                    r_in_att;
    logic [LEN_W-1:0]        r_rem;
    logic                    r_ramp;
    logic                    r_gmode;
    logic [LEN_W-1:0]        r_gx;
    logic [LEN_W-1:0]        r_gn;
    logic [LEN_W-1:0]        r_grcp;
    logic [GAIN_W-1:0]       r_gain;
    logic [MAG_W-1:0]        r_rom_mag;
    logic                    r_rom_neg;
    logic [MAG_W-1:0]        r_sm_mag;
    logic                    r_sm_neg;
    logic [MAG_W-1:0]        r_sv_mag;
    logic                    r_sv_neg;
    logic [SMP_W-1:0]        r_voice_mag;
    logic [LEN_W-1:0]        r_dmag;
    logic [PHASE_W-1:0]      r_step;
    logic signed [SMP_W-1:0] r_sample;
    logic                    r_done;
    logic                    r_clip;

    logic                    r_out_valid;
    t_out_res                r_out_data;

    logic                    in_acc;
    logic                    out_free;
    logic [CMP_W-1:0]        idx_ext;
    logic                    active_now;
    logic                    in_rel;
    logic [LEN_W-1:0]        gain_d;
    logic [PHASE_W-1:0]      rom_phase;
    logic [SINE_BITS-1:0]    rom_k;
    logic [SINE_ADDR_W-1:0]  rom_j;
    logic [SINE_ADDR_W-1:0]  rom_addr;
    logic [GAIN_W-1:0]       gain_now;
    logic signed [SMP_W+1:0] voice_s;
    logic signed [SMP_W+1:0] sum_s;
    logic [PHASE_W-1:0]      dev;

    logic                    div_start;
    logic [LEN_W-1:0]        div_den;
    logic                    div_busy;
    logic [LEN_W-1:0]        div_quot;

    logic                    mul_idle;
    logic                    mul0_start;
    logic [MUL_A_W-1:0]      mul0_a;
    logic [MUL_B_W-1:0]      mul0_b;
    logic                    mul0_busy;
    logic [MUL_P_W-1:0]      mul0_prod;
    logic                    mul1_start;
    logic [MUL_A_W-1:0]      mul1_a;
    logic [MUL_B_W-1:0]      mul1_b;
    logic                    mul1_busy;
    logic [MUL_P_W-1:0]      mul1_prod;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign idx_ext    = CMP_W'(r_sample_index);
    assign active_now = idx_ext < CMP_W'(r_duration);
    assign in_rel     = !r_in_att && (r_rem < r_release);
    assign gain_d     = r_gn - r_gx;
    assign mul_idle   = !mul0_busy && !mul1_busy;

    // The table holds one quarter wave; odd quadrants read it backwards and
    // the second half of the cycle is negated.
    assign rom_phase = (r_state == ST_ROM_M) ? r_main_phase : r_vib_phase;
    assign rom_k     = rom_phase[PHASE_W-1 -: SINE_BITS];
    assign rom_j     = {1'b0, rom_k[SINE_BITS-3:0]};
    assign rom_addr  = rom_k[SINE_BITS-2] ? SINE_ADDR_W'(SINE_QUARTER) - rom_j : rom_j;

    always_ff @(posedge i_clk) begin
        r_rom_mag <= SINE_ROM[rom_addr];
        r_rom_neg <= rom_k[SINE_BITS-1];
    end

    assign gain_now = (r_ramp && !r_gmode) ? mul0_prod[GAIN_W+7:8] : r_gain;

    assign div_start = (in_acc && (i_in_data.opcode == OP_LOAD))
                    || ((r_state == ST_DIV_A) && !div_busy);
    assign div_den   = (r_state == ST_IDLE) ? i_in_data.attack_length : r_release;

    assign mul0_start = (r_state == ST_MUL_S) || ((r_state == ST_MUL_A) && mul_idle);
    assign mul1_start = mul0_start;

    always_comb begin
        if (r_state == ST_MUL_S) begin
            mul0_a = MUL_A_W'(r_gx);
            mul0_b = r_grcp;
            mul1_a = MUL_A_W'(r_volume);
            mul1_b = MUL_B_W'(r_sm_mag);
        end else begin
            mul0_a = mul1_prod[MUL_A_W-1:0];
            mul0_b = MUL_B_W'(gain_now);
            mul1_a = MUL_A_W'(r_vib_depth);
            mul1_b = MUL_B_W'(r_sv_mag);
        end
    end

    svve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    svve_mul u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul0_start),
        .i_a     (mul0_a),
        .i_b     (mul0_b),
        .o_busy  (mul0_busy),
        .o_prod  (mul0_prod)
    );

    svve_mul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul1_start),
        .i_a     (mul1_a),
        .i_b     (mul1_b),
        .o_busy  (mul1_busy),
        .o_prod  (mul1_prod)
    );

    always_comb begin
        voice_s = '0;
        if (r_active) begin
            voice_s = r_sm_neg ? -$signed({2'b00, r_voice_mag}) : $signed({2'b00, r_voice_mag});
        end
        sum_s = $signed({{2{r_mix[SMP_W-1]}}, r_mix}) + voice_s;
        dev   = r_sv_neg ? -PHASE_W'(r_dmag) : PHASE_W'(r_dmag);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.opcode == OP_LOAD) begin
                        n_state = ST_DIV_A;
                    end else begin
                        n_state = active_now ? ST_ROM_M : ST_SUM;
                    end
                end
            end
            ST_DIV_A: begin
                if (!div_busy) begin
                    n_state = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (!div_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ROM_M: n_state = ST_ROM_V;
            ST_ROM_V: n_state = ST_MUL_S;
            ST_MUL_S: n_state = ST_MUL_A;
            ST_MUL_A: begin
                if (mul_idle) begin
                    n_state = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mul_idle) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_vib_rate     <= '0;
            r_vib_depth    <= '0;
            r_att_mode     <= 1'b0;
            r_rel_mode     <= 1'b0;
            r_base_inc     <= '0;
            r_volume       <= '0;
            r_duration     <= '0;
            r_attack       <= '0;
            r_release      <= '0;
            r_att_rcp      <= '0;
            r_rel_rcp      <= '0;
            r_main_phase   <= '0;
            r_vib_phase    <= '0;
            r_sample_index <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_VIB_RATE:  r_vib_rate  <= i_cfg_data[PHASE_W-1:0];
                    CFG_VIB_DEPTH: r_vib_depth <= i_cfg_data[LEN_W-1:0];
                    CFG_ATT_MODE:  r_att_mode  <= i_cfg_data[0];
                    CFG_REL_MODE:  r_rel_mode  <= i_cfg_data[0];
                endcase
            end

            if (in_acc && (i_in_data.opcode == OP_LOAD)) begin
                r_base_inc     <= i_in_data.note_phase_inc;
                r_volume       <= i_in_data.note_volume;
                r_duration     <= i_in_data.note_length;
                r_attack       <= i_in_data.attack_length;
                r_release      <= i_in_data.release_length;
                r_main_phase   <= '0;
                r_vib_phase    <= '0;
                r_sample_index <= '0;
            end

            if ((r_state == ST_DIV_A) && !div_busy) begin
                r_att_rcp <= div_quot;
            end
            if ((r_state == ST_DIV_R) && !div_busy) begin
                r_rel_rcp <= div_quot;
            end

            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_active) begin
                    r_main_phase   <= r_main_phase + r_step;
                    r_vib_phase    <= r_vib_phase + r_vib_rate;
                    r_sample_index <= r_sample_index + COUNT_BITS'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.opcode == OP_TICK)) begin
            r_mix    <= i_in_data.mix_in;
            r_active <= active_now;
            r_in_att <= idx_ext < CMP_W'(r_attack);
            r_rem    <= r_duration - idx_ext[LEN_W-1:0];
        end

        if (r_state == ST_ROM_M) begin
            r_ramp  <= r_in_att || in_rel;
            r_gmode <= r_in_att ? r_att_mode : r_rel_mode;
            r_gx    <= r_in_att ? idx_ext[LEN_W-1:0] : r_rem;
            r_gn    <= r_in_att ? r_attack : r_release;
            r_grcp  <= r_in_att ? r_att_rcp : r_rel_rcp;
        end

        if (r_state == ST_ROM_V) begin
            r_sm_mag <= r_rom_mag;
            r_sm_neg <= r_rom_neg;
            if (!r_ramp) begin
                r_gain <= GAIN_ONE;
            end else if (gain_d < LEN_W'(EXP_LIMIT)) begin
                r_gain <= EXP_ROM[gain_d[EXP_IDX_W-1:0]];
            end else begin
                r_gain <= '0;
            end
        end

        if (r_state == ST_MUL_S) begin
            r_sv_mag <= r_rom_mag;
            r_sv_neg <= r_rom_neg;
        end

        if ((r_state == ST_MUL_B) && mul_idle) begin
            r_voice_mag <= mul0_prod[SMP_W+30:31];
            r_dmag      <= mul1_prod[LEN_W+14:15];
        end

        if (r_state == ST_SUM) begin
            r_done <= r_active && (r_rem == LEN_W'(1));
            r_step <= r_base_inc + dev;
            if (sum_s[SMP_W+1:SMP_W-1] == 3'b000 || sum_s[SMP_W+1:SMP_W-1] == 3'b111) begin
                r_sample <= sum_s[SMP_W-1:0];
                r_clip   <= 1'b0;
            end else begin
                r_sample <= sum_s[SMP_W+1] ? {1'b1, {(SMP_W-1){1'b0}}}
                                           : {1'b0, {(SMP_W-1){1'b1}}};
                r_clip   <= 1'b1;
            end
        end

        if ((r_state == ST_OUT) && out_free) begin
            r_out_data.sample_out <= r_sample;
            r_out_data.note_done  <= r_done;
            r_out_data.clipped    <= r_clip;
        end
    end

`ifndef ASSERT_OFF
    a_load_goes_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.opcode == OP_LOAD)) |=> (r_state == ST_DIV_A))
        else $error("load request did not start the reciprocal division");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!mul0_busy && !mul1_busy && !div_busy))
        else $error("arithmetic unit busy while the voice is idle");

    a_index_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != ST_OUT && $past(r_state) != ST_IDLE) |-> $stable(r_sample_index))
        else $error("sample index moved outside the write-back step");

    a_done_needs_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (!r_done || r_active))
        else $error("note end flagged on a silent voice");
`endif

endmodule

`default_nettype wire
